// ===== sv/kwl_pkg.sv =====
// kwl_pkg: shared types, token codes and keyword tables for the keyword token lexer.
// Used by kwl_scan, kwl_queue, keyword_token_lexer and the port checker; no dependencies.

package kwl_pkg;

   // offset range and saturation limit
   localparam int OffsetBits = 16;
   localparam logic [15:0] SatLimit =
      (OffsetBits >= 16) ? 16'hFFFF : 16'((64'd1 << OffsetBits) - 64'd1);

   localparam int NumKw = 12;
   localparam logic [NumKw-1:0] KwAll = '1;

   // result queue
   localparam int QueueDepth = 4;
   localparam int QueuePtrBits = $clog2(QueueDepth);

   // stream packing
   localparam int ReqDataBits = 8;
   localparam int RspDataBits = 40;

   // token kinds
   localparam logic [4:0] KindEnd     = 5'd0;
   localparam logic [4:0] KindUnknown = 5'd1;
   localparam logic [4:0] KindIdent   = 5'd2;
   localparam logic [4:0] KindInt     = 5'd3;
   localparam logic [4:0] KindEqual   = 5'd4;
   localparam logic [4:0] KindHash    = 5'd5;
   localparam logic [4:0] KindPlus    = 5'd6;
   localparam logic [4:0] KindMinus   = 5'd7;
   localparam logic [4:0] KindStar    = 5'd8;
   localparam logic [4:0] KindSlash   = 5'd9;
   localparam logic [4:0] KindLParen  = 5'd10;
   localparam logic [4:0] KindRParen  = 5'd11;
   localparam logic [4:0] KindComma   = 5'd12;
   localparam logic [4:0] KindSemi    = 5'd13;
   localparam logic [4:0] KindDot     = 5'd14;
   localparam logic [4:0] KindAssign  = 5'd15;
   localparam logic [4:0] KindColon   = 5'd16;
   localparam logic [4:0] KindKwBase  = 5'd17;
   localparam logic [4:0] KindMax     = 5'd28;

   // keyword spellings, right-justified: first letter in the highest used byte
   localparam logic [71:0] KwText [NumKw] = '{
      72'("MODULE"), 72'("IMPORT"), 72'("PROCEDURE"), 72'("BEGIN"),
      72'("END"), 72'("VAR"), 72'("IF"), 72'("THEN"),
      72'("ELSE"), 72'("WHILE"), 72'("DO"), 72'("RETURN")
   };
   localparam logic [3:0] KwLen [NumKw] = '{
      4'd6, 4'd6, 4'd9, 4'd5, 4'd3, 4'd3, 4'd2, 4'd4, 4'd4, 4'd5, 4'd2, 4'd6
   };

   typedef enum logic [1:0] {
      RunIdle   = 2'd0,
      RunDigit  = 2'd1,
      RunLetter = 2'd2,
      RunColon  = 2'd3
   } run_class_type;

   typedef struct packed {
      logic        last;
      logic [15:0] length;
      logic [15:0] start;
      logic [4:0]  kind;
   } token_type;

   // tokens caused by one byte, already in output order
   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } push_type;

   function automatic logic [15:0] sat_inc(logic [15:0] v);
      logic [15:0] r;
      r = (v >= SatLimit) ? SatLimit : v + 16'd1;
      return r;
   endfunction

   // keywords whose letter at position idx equals c
   function automatic logic [NumKw-1:0] letter_match(logic [15:0] idx, logic [7:0] c);
      logic [NumKw-1:0] m;
      int unsigned      pos;
      m = '0;
      for (int k = 0; k < NumKw; k++) begin
         if (idx < {12'd0, KwLen[k]}) begin
            pos = 32'(KwLen[k]) - 32'd1 - 32'(idx[3:0]);
            m[k] = (KwText[k][8*pos +: 8] == c);
         end
      end
      return m;
   endfunction

   function automatic logic [4:0] op_kind(logic [7:0] c);
      logic [4:0] k;
      case (c)
         8'h3D:   k = KindEqual;
         8'h23:   k = KindHash;
         8'h2B:   k = KindPlus;
         8'h2D:   k = KindMinus;
         8'h2A:   k = KindStar;
         8'h2F:   k = KindSlash;
         8'h28:   k = KindLParen;
         8'h29:   k = KindRParen;
         8'h2C:   k = KindComma;
         8'h3B:   k = KindSemi;
         8'h2E:   k = KindDot;
         default: k = KindUnknown;
      endcase
      return k;
   endfunction

endpackage

// ===== sv/kwl_scan.sv =====
// kwl_scan: per-byte scanner state (run class, run start/length, keyword candidates,
// byte position) and the up to two tokens each byte causes. Depends on kwl_pkg.

module kwl_scan (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        ch,
   output kwl_pkg::push_type push
);

   kwl_pkg::run_class_type     run_class_ff, run_class_in;
   logic [15:0]                run_start_ff, run_start_in;
   logic [15:0]                run_length_ff, run_length_in;
   logic [kwl_pkg::NumKw-1:0]  cand_ff, cand_in;
   logic [15:0]                byte_pos_ff, byte_pos_in;

   logic is_end, is_digit, is_letter, is_space, is_colon, is_eq;
   logic [4:0] run_kind;

   always_comb begin
      is_end    = (ch == 8'h00);
      is_digit  = (ch >= 8'h30) && (ch <= 8'h39);
      is_letter = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
      is_space  = (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
      is_colon  = (ch == 8'h3A);
      is_eq     = (ch == 8'h3D);
   end

   // kind of the pending letter, digit or colon run if it were closed now
   always_comb begin
      run_kind = kwl_pkg::KindIdent;
      for (int k = kwl_pkg::NumKw - 1; k >= 0; k--) begin
         if (cand_ff[k] && (run_length_ff == {12'd0, kwl_pkg::KwLen[k]})) begin
            run_kind = kwl_pkg::KindKwBase + 5'(k);
         end
      end
      if (run_class_ff == kwl_pkg::RunDigit) begin
         run_kind = kwl_pkg::KindInt;
      end
      if (run_class_ff == kwl_pkg::RunColon) begin
         run_kind = kwl_pkg::KindColon;
      end
   end

   // next state
   always_comb begin
      run_class_in  = kwl_pkg::RunIdle;
      run_start_in  = run_start_ff;
      run_length_in = 16'd0;
      cand_in       = kwl_pkg::KwAll;
      byte_pos_in   = is_end ? 16'd0 : kwl_pkg::sat_inc(byte_pos_ff);
      if (is_end) begin
         run_start_in = 16'd0;
      end else if ((run_class_ff == kwl_pkg::RunColon) && is_eq) begin
         cand_in = cand_ff;
      end else if (is_digit) begin
         run_class_in = kwl_pkg::RunDigit;
         if (run_class_ff == kwl_pkg::RunDigit) begin
            run_length_in = kwl_pkg::sat_inc(run_length_ff);
         end else begin
            run_start_in  = byte_pos_ff;
            run_length_in = 16'd1;
         end
      end else if (is_letter) begin
         run_class_in = kwl_pkg::RunLetter;
         if (run_class_ff == kwl_pkg::RunLetter) begin
            cand_in       = cand_ff & kwl_pkg::letter_match(run_length_ff, ch);
            run_length_in = kwl_pkg::sat_inc(run_length_ff);
         end else begin
            cand_in       = kwl_pkg::letter_match(16'd0, ch);
            run_start_in  = byte_pos_ff;
            run_length_in = 16'd1;
         end
      end else if (is_colon) begin
         run_class_in  = kwl_pkg::RunColon;
         run_start_in  = byte_pos_ff;
         run_length_in = 16'd1;
      end
   end

   // tokens: slot a closes the pending run, slot b is the byte's own token
   logic                a_valid, b_valid;
   kwl_pkg::token_type  tok_a, tok_b;

   always_comb begin
      tok_a.kind   = run_kind;
      tok_a.start  = run_start_ff;
      tok_a.length = (run_class_ff == kwl_pkg::RunColon) ? 16'd1 : run_length_ff;
      tok_a.last   = 1'b0;
      a_valid      = run_class_ff != kwl_pkg::RunIdle;
      b_valid      = 1'b0;
      tok_b.kind   = kwl_pkg::op_kind(ch);
      tok_b.start  = byte_pos_ff;
      tok_b.length = 16'd1;
      tok_b.last   = 1'b1;
      if (is_end) begin
         b_valid    = 1'b1;
         tok_b.kind = kwl_pkg::KindEnd;
      end else if ((run_class_ff == kwl_pkg::RunColon) && is_eq) begin
         a_valid      = 1'b0;
         b_valid      = 1'b1;
         tok_b.kind   = kwl_pkg::KindAssign;
         tok_b.start  = run_start_ff;
         tok_b.length = 16'd2;
      end else if (is_digit) begin
         a_valid = a_valid && (run_class_ff != kwl_pkg::RunDigit);
      end else if (is_letter) begin
         a_valid = a_valid && (run_class_ff != kwl_pkg::RunLetter);
      end else if (!is_space && !is_colon) begin
         b_valid = 1'b1;
      end
      tok_a.last  = !b_valid;
      push.count  = {1'b0, a_valid} + {1'b0, b_valid};
      push.first  = a_valid ? tok_a : tok_b;
      push.second = tok_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_class_ff  <= kwl_pkg::RunIdle;
         run_start_ff  <= 16'd0;
         run_length_ff <= 16'd0;
         cand_ff       <= kwl_pkg::KwAll;
         byte_pos_ff   <= 16'd0;
      end else if (take) begin
         run_class_ff  <= run_class_in;
         run_start_ff  <= run_start_in;
         run_length_ff <= run_length_in;
         cand_ff       <= cand_in;
         byte_pos_ff   <= byte_pos_in;
      end
   end

endmodule

// ===== sv/kwl_queue.sv =====
// kwl_queue: small token queue between the scanner and the result stream; takes up
// to two tokens per transfer and hands out one per cycle while out_ready is high. Depends on kwl_pkg.

module kwl_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_en,
   input  kwl_pkg::push_type  push,
   output logic               room,
   output logic               out_valid,
   input  logic               out_ready,
   output kwl_pkg::token_type out_token
);

   localparam int PB = kwl_pkg::QueuePtrBits;

   kwl_pkg::token_type entry_ff [kwl_pkg::QueueDepth];
   logic [PB-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PB:0]        count_ff, count_in;
   logic [PB:0]        push_n;
   logic               pop;

   always_comb begin
      room      = count_ff <= (PB+1)'(kwl_pkg::QueueDepth - 2);
      out_valid = count_ff != '0;
      out_token = entry_ff[rd_ptr_ff];
      pop       = out_valid && out_ready;
      push_n    = push_en ? (PB+1)'(push.count) : '0;
      wr_ptr_in = wr_ptr_ff + push_n[PB-1:0];
      rd_ptr_in = rd_ptr_ff + PB'(pop);
      count_in  = count_ff + push_n - (PB+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_en && (push.count != 2'd0)) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push_en && (push.count == 2'd2)) begin
         entry_ff[wr_ptr_ff + PB'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/keyword_token_lexer.sv =====
// keyword_token_lexer: top level; byte stream in, token stream out.
// Depends on kwl_pkg, kwl_scan and kwl_queue.

// Source bytes enter on the req_ stream one per transfer, and a zero byte ends the
// text and resets the offset to 0. Each byte updates the scanner in the cycle it is
// taken and its tokens (none, one or two) land in a four-token queue, so a token
// appears on rsp_ in the cycle after its byte at the earliest. A byte is taken in
// every cycle while the queue has room for two tokens; the result side hands out one
// token per cycle while rsp_tready is high, so a byte that closes a pending run and
// also forms a token of its own gives two tokens in turn. rsp_tlast marks the last
// token caused by a byte. Offsets and run lengths saturate at 65535.

module keyword_token_lexer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [kwl_pkg::ReqDataBits-1:0]   req_tdata,   // [7:0] ch
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [kwl_pkg::RspDataBits-1:0]   rsp_tdata,   // [4:0] token_kind,
                                                          // [20:5] start_offset,
                                                          // [36:21] token_length, 0 above
   output logic                              rsp_tlast    // last token of its byte
);

   logic               take;
   logic               room;
   kwl_pkg::push_type  push;
   kwl_pkg::token_type head;

   assign req_tready = room;
   assign take       = req_tvalid && room;

   kwl_scan u_scan (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .ch    (req_tdata),
      .push  (push)
   );

   kwl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (take),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_token (head)
   );

   assign rsp_tdata = {3'd0, head.length, head.start, head.kind};
   assign rsp_tlast = head.last;

endmodule

// ===== sv/kwl_checker.sv =====
// kwl_checker: port-level checks on the token stream of keyword_token_lexer,
// attached to the top level by the bind below. Depends on kwl_pkg.

module kwl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [kwl_pkg::RspDataBits-1:0] rsp_tdata,
   input logic                            rsp_tlast
);

   // a stalled transfer keeps its token
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("token changed while stalled");

   // the end token closes its byte and is one byte long
   a_end_token: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[4:0] == kwl_pkg::KindEnd)
      |-> rsp_tlast && (rsp_tdata[36:21] == 16'd1))
      else $error("malformed end token");

   // kinds stay in range and padding stays zero
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:0] <= kwl_pkg::KindMax) && (rsp_tdata[39:37] == 3'd0))
      else $error("token kind out of range");

   // no token right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("token present after reset");

endmodule

bind keyword_token_lexer kwl_checker u_kwl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
